### rtl/smec_pkg.sv
// ----------------------------------------------------------------------------
// smec_pkg: shared definitions for the stack machine execute core
// Widths, opcode and fault codes, and the decoded instruction record that
// passes from the front end through the instruction queue to the back end.
// ----------------------------------------------------------------------------
package smec_pkg;

    localparam int DATA_W    = 64;
    localparam int FUNC_W    = 5;
    localparam int FAULT_W   = 3;
    localparam int ADDR_W    = 16;
    localparam int DS_DEPTH  = 64;
    localparam int DS_AW     = $clog2(DS_DEPTH);
    localparam int DEPTH_W   = DS_AW + 1;
    localparam int RS_DEPTH  = 32;
    localparam int RS_AW     = $clog2(RS_DEPTH);
    localparam int RDEPTH_W  = RS_AW + 1;

    localparam logic [FUNC_W-1:0] OP_NOP    = 5'd0;
    localparam logic [FUNC_W-1:0] OP_HALT   = 5'd1;
    localparam logic [FUNC_W-1:0] OP_PUSH   = 5'd2;
    localparam logic [FUNC_W-1:0] OP_POP    = 5'd3;
    localparam logic [FUNC_W-1:0] OP_ADD    = 5'd4;
    localparam logic [FUNC_W-1:0] OP_SUB    = 5'd5;
    localparam logic [FUNC_W-1:0] OP_MUL    = 5'd6;
    localparam logic [FUNC_W-1:0] OP_DIV    = 5'd7;
    localparam logic [FUNC_W-1:0] OP_MOD    = 5'd8;
    localparam logic [FUNC_W-1:0] OP_SWAP   = 5'd9;
    localparam logic [FUNC_W-1:0] OP_DUP    = 5'd10;
    localparam logic [FUNC_W-1:0] OP_INSWAP = 5'd11;
    localparam logic [FUNC_W-1:0] OP_INDUP  = 5'd12;
    localparam logic [FUNC_W-1:0] OP_JMP    = 5'd13;
    localparam logic [FUNC_W-1:0] OP_JZ     = 5'd14;
    localparam logic [FUNC_W-1:0] OP_JLE    = 5'd15;
    localparam logic [FUNC_W-1:0] OP_JGE    = 5'd16;
    localparam logic [FUNC_W-1:0] OP_JL     = 5'd17;
    localparam logic [FUNC_W-1:0] OP_JG     = 5'd18;
    localparam logic [FUNC_W-1:0] OP_CALL   = 5'd19;
    localparam logic [FUNC_W-1:0] OP_RET    = 5'd20;
    localparam logic [FUNC_W-1:0] OP_CMPLE  = 5'd21;
    localparam logic [FUNC_W-1:0] OP_CMPL   = 5'd22;
    localparam logic [FUNC_W-1:0] OP_CMPGE  = 5'd23;
    localparam logic [FUNC_W-1:0] OP_CMPG   = 5'd24;
    localparam logic [FUNC_W-1:0] OP_SSP    = 5'd25;

    localparam logic [FAULT_W-1:0] FLT_NONE   = 3'd0;
    localparam logic [FAULT_W-1:0] FLT_UNDER  = 3'd1;
    localparam logic [FAULT_W-1:0] FLT_OVER   = 3'd2;
    localparam logic [FAULT_W-1:0] FLT_DIVZ   = 3'd3;
    localparam logic [FAULT_W-1:0] FLT_BADPOS = 3'd4;
    localparam logic [FAULT_W-1:0] FLT_RSOVER = 3'd5;
    localparam logic [FAULT_W-1:0] FLT_BADOP  = 3'd6;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] operand;
        logic              is_bin;
        logic              is_div;
        logic              is_idx;
        logic              is_jcc;
    } t_instr;

endpackage

### rtl/smec_front.sv
// ----------------------------------------------------------------------------
// smec_front: instruction intake and decode
// Classifies each incoming instruction and holds it in a two-entry queue
// until the back end takes it.
// ----------------------------------------------------------------------------
module smec_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [smec_pkg::FUNC_W-1:0]   i_func,
    input  logic [smec_pkg::DATA_W-1:0]   i_operand,
    output logic                          o_full,
    input  logic                          i_deq,
    output smec_pkg::t_instr              o_head,
    output logic                          o_head_valid
);
    import smec_pkg::*;

    t_instr      dec;
    t_instr      r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        enq;
    logic        deq;

    always_comb begin
        dec         = '0;
        dec.func    = i_func;
        dec.operand = i_operand;
        dec.is_bin  = (i_func >= OP_ADD && i_func <= OP_MOD) ||
                      (i_func >= OP_CMPLE && i_func <= OP_CMPG);
        dec.is_div  = (i_func == OP_DIV) || (i_func == OP_MOD);
        dec.is_idx  = (i_func == OP_INSWAP) || (i_func == OP_INDUP);
        dec.is_jcc  = (i_func >= OP_JZ) && (i_func <= OP_JG);
    end

    assign o_full       = (r_cnt == 2'd2);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];
    assign enq          = i_push && !o_full;
    assign deq          = i_deq && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (enq) begin
                r_wp <= ~r_wp;
            end
            if (deq) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, enq} - {1'b0, deq};
        end
    end

endmodule

### rtl/smec_div.sv
// ----------------------------------------------------------------------------
// smec_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, giving a
// truncated quotient or a remainder that takes the dividend's sign.
// ----------------------------------------------------------------------------
module smec_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_mod,
    input  logic [smec_pkg::DATA_W-1:0]   i_a,
    input  logic [smec_pkg::DATA_W-1:0]   i_b,
    output logic                          o_done,
    output logic [smec_pkg::DATA_W-1:0]   o_result
);
    import smec_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W-1:0]   r_q;
    logic [DATA_W-1:0]   r_r;
    logic [DATA_W-1:0]   r_mb;
    logic                r_neg;
    logic                r_mod;
    logic [DATA_W:0]     trial;
    logic [DATA_W:0]     diff;
    logic [DATA_W-1:0]   mag;

    assign trial = {r_r, r_q[DATA_W-1]};
    assign diff  = trial - {1'b0, r_mb};
    assign mag   = r_mod ? r_r : r_q;
    assign o_result = r_neg ? (~mag + 1'b1) : mag;
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
            r_mb  <= i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;
            r_r   <= '0;
            r_mod <= i_mod;
            r_neg <= i_mod ? i_a[DATA_W-1] : (i_a[DATA_W-1] ^ i_b[DATA_W-1]);
        end else if (r_busy) begin
            if (!diff[DATA_W]) begin
                r_r <= diff[DATA_W-1:0];
                r_q <= {r_q[DATA_W-2:0], 1'b1};
            end else begin
                r_r <= trial[DATA_W-1:0];
                r_q <= {r_q[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(DATA_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

### rtl/smec_back.sv
// ----------------------------------------------------------------------------
// smec_back: instruction execution
// Owns the data and return stacks, pointer, depth and halt state; runs one
// instruction at a time through a small sequencer and registers the result.
// ----------------------------------------------------------------------------
module smec_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smec_pkg::t_instr               i_head,
    input  logic                           i_head_valid,
    output logic                           o_deq,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [smec_pkg::ADDR_W-1:0]    o_next_address,
    output logic [smec_pkg::DATA_W-1:0]    o_top_value,
    output logic [smec_pkg::DEPTH_W-1:0]   o_depth,
    output logic                           o_stopped,
    output logic [smec_pkg::FAULT_W-1:0]   o_fault
);
    import smec_pkg::*;

    localparam logic [2:0] ST_ISSUE = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_WR2   = 3'd5;
    localparam logic [2:0] ST_TOPA  = 3'd6;
    localparam logic [2:0] ST_TOPD  = 3'd7;

    logic [2:0]          r_state;
    t_instr              r_ins;
    logic [DEPTH_W-1:0]  r_d;
    logic [RDEPTH_W-1:0] r_rd;
    logic [ADDR_W-1:0]   r_ip;
    logic                r_halt;
    logic [FAULT_W-1:0]  r_fault;

    logic [DATA_W-1:0]   r_ds_mem [DS_DEPTH];
    logic [ADDR_W-1:0]   r_rs_mem [RS_DEPTH];
    logic [DATA_W-1:0]   r_ra;
    logic [DATA_W-1:0]   r_rb;
    logic [ADDR_W-1:0]   r_rs_q;

    logic [DS_AW-1:0]    r_w1a;
    logic [DATA_W-1:0]   r_w1d;
    logic [DS_AW-1:0]    r_w2a;
    logic [DATA_W-1:0]   r_w2d;
    logic                r_w2en;

    logic [DATA_W-1:0]   r_opa;
    logic [DATA_W-1:0]   r_opb;
    logic [DATA_W-1:0]   r_acc;
    logic [1:0]          r_mcnt;

    logic                r_ovalid;
    logic [ADDR_W-1:0]   r_o_ip;
    logic [DATA_W-1:0]   r_o_top;
    logic [DEPTH_W-1:0]  r_o_d;
    logic                r_o_halt;
    logic [FAULT_W-1:0]  r_o_fault;

    logic [DS_AW-1:0]    addr_a;
    logic [DS_AW-1:0]    addr_b;
    logic [DEPTH_W-1:0]  idx_pos;
    logic                ds_we;
    logic [DS_AW-1:0]    ds_wa;
    logic [DATA_W-1:0]   ds_wd;
    logic                rs_we;

    logic [FAULT_W-1:0]  flt;
    logic                v_ge_d;
    logic                jtaken;
    logic [DATA_W-1:0]   alu;
    logic [ADDR_W-1:0]   nxt;
    logic [ADDR_W-1:0]   target;
    logic [31:0]         mx;
    logic [31:0]         my;
    logic [DATA_W-1:0]   prod;
    logic [DATA_W-1:0]   acc_sum;
    logic                div_start;
    logic                div_done;
    logic [DATA_W-1:0]   div_res;
    logic                out_load;

    // Read addresses: port A always reads the current top; port B reads
    // the second entry or the indexed entry of the instruction at the head.
    assign idx_pos = r_d - DEPTH_W'(1) - i_head.operand[DEPTH_W-1:0];
    assign addr_a  = DS_AW'(r_d - DEPTH_W'(1));
    assign addr_b  = i_head.is_idx ? idx_pos[DS_AW-1:0] : DS_AW'(r_d - DEPTH_W'(2));

    assign ds_we = (r_state == ST_WR) || (r_state == ST_WR2);
    assign ds_wa = (r_state == ST_WR2) ? r_w2a : r_w1a;
    assign ds_wd = (r_state == ST_WR2) ? r_w2d : r_w1d;

    always_ff @(posedge i_clk) begin
        if (ds_we) begin
            r_ds_mem[ds_wa] <= ds_wd;
        end
        r_ra <= r_ds_mem[addr_a];
        r_rb <= r_ds_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            r_rs_mem[r_rd[RS_AW-1:0]] <= r_ip;
        end
        r_rs_q <= r_rs_mem[RS_AW'(r_rd - RDEPTH_W'(1))];
    end

    assign nxt    = r_ip + 1'b1;
    assign target = r_ins.operand[ADDR_W-1:0];
    assign v_ge_d = (|r_ins.operand[DATA_W-1:DEPTH_W]) ||
                    (r_ins.operand[DEPTH_W-1:0] >= r_d);

    always_comb begin
        priority case (r_ins.func)
            OP_JZ:   jtaken = (r_ra == '0);
            OP_JLE:  jtaken = r_ra[DATA_W-1] || (r_ra == '0);
            OP_JGE:  jtaken = !r_ra[DATA_W-1];
            OP_JL:   jtaken = r_ra[DATA_W-1];
            default: jtaken = !r_ra[DATA_W-1] && (r_ra != '0);
        endcase
    end

    // Operands for two-input operations: a is below the top, b is the top.
    always_comb begin
        priority case (r_ins.func)
            OP_ADD:   alu = r_rb + r_ra;
            OP_SUB:   alu = r_rb - r_ra;
            OP_CMPLE: alu = DATA_W'($signed(r_rb) <= $signed(r_ra));
            OP_CMPL:  alu = DATA_W'($signed(r_rb) <  $signed(r_ra));
            OP_CMPGE: alu = DATA_W'($signed(r_rb) >= $signed(r_ra));
            default:  alu = DATA_W'($signed(r_rb) >  $signed(r_ra));
        endcase
    end

    always_comb begin
        flt = FLT_NONE;
        if (r_ins.is_bin) begin
            if (r_d < DEPTH_W'(2)) begin
                flt = FLT_UNDER;
            end else if (r_ins.is_div && (r_ra == '0)) begin
                flt = FLT_DIVZ;
            end
        end else if (r_ins.is_jcc) begin
            if (r_d == '0) begin
                flt = FLT_UNDER;
            end
        end else begin
            priority case (r_ins.func)
                OP_PUSH: begin
                    if (r_d >= DEPTH_W'(DS_DEPTH)) flt = FLT_OVER;
                end
                OP_POP: begin
                    if (r_d == '0) flt = FLT_UNDER;
                end
                OP_SWAP: begin
                    if (r_d < DEPTH_W'(2)) flt = FLT_UNDER;
                end
                OP_DUP: begin
                    if (r_d == '0) flt = FLT_UNDER;
                    else if (r_d >= DEPTH_W'(DS_DEPTH)) flt = FLT_OVER;
                end
                OP_INSWAP: begin
                    if (v_ge_d) flt = FLT_BADPOS;
                end
                OP_INDUP: begin
                    if (v_ge_d) flt = FLT_BADPOS;
                    else if (r_d >= DEPTH_W'(DS_DEPTH)) flt = FLT_OVER;
                end
                OP_CALL: begin
                    if (r_rd >= RDEPTH_W'(RS_DEPTH)) flt = FLT_RSOVER;
                end
                OP_SSP: begin
                    if (r_d == '0) begin
                        flt = FLT_UNDER;
                    end else if ((|r_ra[DATA_W-1:DEPTH_W]) ||
                                 (r_ra[DEPTH_W-1:0] > DEPTH_W'(DS_DEPTH))) begin
                        flt = FLT_BADPOS;
                    end
                end
                default: begin
                    if (r_ins.func > OP_SSP) flt = FLT_BADOP;
                end
            endcase
        end
    end

    assign rs_we = (r_state == ST_EXEC) && !r_halt && (flt == FLT_NONE) &&
                   (r_ins.func == OP_CALL);

    // 64-bit wrapping product from three 32x32 partial products.
    always_comb begin
        priority case (r_mcnt)
            2'd0:    begin mx = r_opa[31:0];  my = r_opb[31:0];  end
            2'd1:    begin mx = r_opa[31:0];  my = r_opb[63:32]; end
            default: begin mx = r_opa[63:32]; my = r_opb[31:0];  end
        endcase
    end
    assign prod    = mx * my;
    assign acc_sum = r_acc + {prod[31:0], 32'd0};

    assign div_start = (r_state == ST_EXEC) && !r_halt && (flt == FLT_NONE) &&
                       r_ins.is_div;

    smec_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_mod    (r_ins.func == OP_MOD),
        .i_a      (r_rb),
        .i_b      (r_ra),
        .o_done   (div_done),
        .o_result (div_res)
    );

    assign o_deq    = (r_state == ST_ISSUE) && i_head_valid;
    assign out_load = (r_state == ST_TOPD) && (!r_ovalid || i_pop);

    always_ff @(posedge i_clk) begin
        if (o_deq) begin
            r_ins <= i_head;
        end
        if (r_state == ST_EXEC) begin
            r_opa  <= r_rb;
            r_opb  <= r_ra;
            r_mcnt <= '0;
            r_w2en <= (r_ins.func == OP_SWAP) || (r_ins.func == OP_INSWAP);
            priority case (r_ins.func)
                OP_PUSH: begin
                    r_w1a <= r_d[DS_AW-1:0];
                    r_w1d <= r_ins.operand;
                end
                OP_SWAP: begin
                    r_w1a  <= DS_AW'(r_d - DEPTH_W'(1));
                    r_w1d  <= r_rb;
                    r_w2a  <= DS_AW'(r_d - DEPTH_W'(2));
                    r_w2d  <= r_ra;
                end
                OP_DUP: begin
                    r_w1a <= r_d[DS_AW-1:0];
                    r_w1d <= r_ra;
                end
                OP_INSWAP: begin
                    r_w1a  <= DS_AW'(r_d - DEPTH_W'(1));
                    r_w1d  <= r_rb;
                    r_w2a  <= DS_AW'(r_d - DEPTH_W'(1) - r_ins.operand[DEPTH_W-1:0]);
                    r_w2d  <= r_ra;
                end
                OP_INDUP: begin
                    r_w1a <= r_d[DS_AW-1:0];
                    r_w1d <= r_rb;
                end
                default: begin
                    r_w1a <= DS_AW'(r_d - DEPTH_W'(2));
                    r_w1d <= alu;
                end
            endcase
        end else if (r_state == ST_MUL) begin
            r_mcnt <= r_mcnt + 1'b1;
            r_acc  <= (r_mcnt == 2'd0) ? prod : acc_sum;
            if (r_mcnt == 2'd2) begin
                r_w1d <= acc_sum;
            end
        end else if (r_state == ST_DIV && div_done) begin
            r_w1d <= div_res;
        end
        if (out_load) begin
            r_o_ip    <= r_ip;
            r_o_top   <= (r_d == '0) ? '0 : r_ra;
            r_o_d     <= r_d;
            r_o_halt  <= r_halt;
            r_o_fault <= r_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ISSUE;
            r_d      <= '0;
            r_rd     <= '0;
            r_ip     <= '0;
            r_halt   <= 1'b0;
            r_fault  <= FLT_NONE;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_ISSUE: begin
                    r_fault <= FLT_NONE;
                    if (i_head_valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (r_halt) begin
                        r_state <= ST_TOPA;
                    end else if (flt != FLT_NONE) begin
                        r_state <= ST_TOPA;
                        r_halt  <= 1'b1;
                        r_fault <= flt;
                    end else if (r_ins.is_bin) begin
                        r_d  <= r_d - DEPTH_W'(1);
                        r_ip <= nxt;
                        if (r_ins.is_div) begin
                            r_state <= ST_DIV;
                        end else if (r_ins.func == OP_MUL) begin
                            r_state <= ST_MUL;
                        end else begin
                            r_state <= ST_WR;
                        end
                    end else if (r_ins.is_jcc) begin
                        r_state <= ST_TOPA;
                        r_d     <= r_d - DEPTH_W'(1);
                        r_ip    <= jtaken ? target : nxt;
                    end else begin
                        // Pushes, duplicates and swaps go through the write states.
                        r_state <= ((r_ins.func == OP_PUSH) || (r_ins.func == OP_DUP) ||
                                    (r_ins.func == OP_INDUP) || (r_ins.func == OP_SWAP) ||
                                    (r_ins.func == OP_INSWAP)) ? ST_WR : ST_TOPA;
                        priority case (r_ins.func)
                            OP_NOP: r_ip <= nxt;
                            OP_HALT: r_halt <= 1'b1;
                            OP_PUSH, OP_DUP, OP_INDUP: begin
                                r_d     <= r_d + DEPTH_W'(1);
                                r_ip    <= nxt;
                            end
                            OP_POP: begin
                                r_d  <= r_d - DEPTH_W'(1);
                                r_ip <= nxt;
                            end
                            OP_SWAP, OP_INSWAP: begin
                                r_ip    <= nxt;
                            end
                            OP_JMP: r_ip <= target;
                            OP_CALL: begin
                                r_rd <= r_rd + RDEPTH_W'(1);
                                r_ip <= target;
                            end
                            OP_RET: begin
                                if (r_rd == '0) begin
                                    r_halt <= 1'b1;
                                end else begin
                                    r_rd <= r_rd - RDEPTH_W'(1);
                                    r_ip <= r_rs_q + 1'b1;
                                end
                            end
                            default: begin
                                r_d  <= r_ra[DEPTH_W-1:0];
                                r_ip <= nxt;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    if (r_mcnt == 2'd2) begin
                        r_state <= ST_WR;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    r_state <= r_w2en ? ST_WR2 : ST_TOPA;
                end
                ST_WR2: begin
                    r_state <= ST_TOPA;
                end
                ST_TOPA: begin
                    r_state <= ST_TOPD;
                end
                ST_TOPD: begin
                    if (out_load) begin
                        r_state <= ST_ISSUE;
                    end
                end
                default: r_state <= ST_ISSUE;
            endcase
        end
    end

    assign o_empty        = !r_ovalid;
    assign o_next_address = r_o_ip;
    assign o_top_value    = r_o_top;
    assign o_depth        = r_o_d;
    assign o_stopped      = r_o_halt;
    assign o_fault        = r_o_fault;

endmodule

### rtl/stack_machine_execute_core.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_core: stack machine instruction executor
// Executes one instruction per beat against a data stack, a return stack,
// an instruction pointer and a halt flag, and returns one status beat each.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Beat contents
//   -------   ---------  ---------------  -------------------------------------
//   instr     in         i_push / o_full  i_func, i_operand
//   status    out        o_empty / i_pop  o_next_address, o_top_value, o_depth,
//                                         o_stopped, o_fault
//
// An instruction passes through the back end as issue, execute, zero, one or
// two stack writes and a top-of-stack read; multiply first runs its partial
// products on the shared 32x32 multiplier and divide or modulo waits on the
// bit-serial divider. The two-entry queue in the front end accepts beats
// until it holds two while the back end works or waits on a full status
// register. Reset is synchronous and active low; it empties both stacks,
// clears the pointer and the halt flag, and needs no clearing pass.
//
module stack_machine_execute_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [smec_pkg::FUNC_W-1:0]    i_func,
    input  logic [smec_pkg::DATA_W-1:0]    i_operand,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [smec_pkg::ADDR_W-1:0]    o_next_address,
    output logic [smec_pkg::DATA_W-1:0]    o_top_value,
    output logic [smec_pkg::DEPTH_W-1:0]   o_depth,
    output logic                           o_stopped,
    output logic [smec_pkg::FAULT_W-1:0]   o_fault
);
    import smec_pkg::*;

    t_instr head;
    logic   head_valid;
    logic   deq;

    // The front end decodes each beat and queues it for execution.
    smec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_func       (i_func),
        .i_operand    (i_operand),
        .o_full       (o_full),
        .i_deq        (deq),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    // The back end runs one queued instruction at a time and holds its
    // status beat in an output register until it is popped.
    smec_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_valid   (head_valid),
        .o_deq          (deq),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_next_address (o_next_address),
        .o_top_value    (o_top_value),
        .o_depth        (o_depth),
        .o_stopped      (o_stopped),
        .o_fault        (o_fault)
    );

endmodule

### tb/sv/smec_checker.sv
// ----------------------------------------------------------------------------
// smec_checker: status prediction and comparison for the execute core
// Watches both channels of the core, runs its own model of the stack machine
// for every accepted instruction beat, and compares every status beat.
// ----------------------------------------------------------------------------
module smec_checker
    import smec_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DATA_W-1:0]   i_operand,
    input  logic                i_empty,
    input  logic                i_pop,
    input  logic [ADDR_W-1:0]   i_next_address,
    input  logic [DATA_W-1:0]   i_top_value,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic                i_stopped,
    input  logic [FAULT_W-1:0]  i_fault,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0]  next_address;
        logic [DATA_W-1:0]  top_value;
        logic [DEPTH_W-1:0] depth;
        logic               stopped;
        logic [FAULT_W-1:0] fault;
    } t_status;

    logic [DATA_W-1:0] dstk [DS_DEPTH];
    logic [ADDR_W-1:0] rstk [RS_DEPTH];
    int unsigned       ddep;
    int unsigned       rdep;
    logic [ADDR_W-1:0] ip;
    logic              halted;
    t_status           status_q [$];

    function automatic logic [DATA_W-1:0] mag(logic [DATA_W-1:0] a);
        return a[DATA_W-1] ? -a : a;
    endfunction

    function automatic logic [DATA_W-1:0] alu(logic [FUNC_W-1:0] op,
                                              logic [DATA_W-1:0] a,
                                              logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] q;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            OP_DIV: begin
                q = mag(a) / mag(b);
                return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
            end
            OP_MOD: begin
                q = mag(a) % mag(b);
                return a[DATA_W-1] ? -q : q;
            end
            OP_CMPLE: return ($signed(a) <= $signed(b)) ? 64'd1 : 64'd0;
            OP_CMPL:  return ($signed(a) <  $signed(b)) ? 64'd1 : 64'd0;
            OP_CMPGE: return ($signed(a) >= $signed(b)) ? 64'd1 : 64'd0;
            default:  return ($signed(a) >  $signed(b)) ? 64'd1 : 64'd0;
        endcase
    endfunction

    function automatic bit branch_taken(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] v);
        case (op)
            OP_JZ:   return v == 0;
            OP_JLE:  return $signed(v) <= 0;
            OP_JGE:  return $signed(v) >= 0;
            OP_JL:   return $signed(v) < 0;
            default: return $signed(v) > 0;
        endcase
    endfunction

    // Executes one instruction on the local machine state; returns the fault.
    // A faulting instruction leaves everything untouched.
    function automatic logic [FAULT_W-1:0] run_instr(logic [FUNC_W-1:0] op,
                                                     logic [DATA_W-1:0] v);
        int unsigned       d;
        logic [ADDR_W-1:0] nxt;
        logic [DATA_W-1:0] t;
        int unsigned       p;
        d   = ddep;
        nxt = ip + 1'b1;
        p   = v[15:0];
        case (op)
            OP_NOP: ip = nxt;
            OP_HALT: halted = 1'b1;
            OP_PUSH: begin
                if (d >= DS_DEPTH) return FLT_OVER;
                dstk[d] = v;
                ddep = d + 1;
                ip = nxt;
            end
            OP_POP: begin
                if (d < 1) return FLT_UNDER;
                ddep = d - 1;
                ip = nxt;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
            OP_CMPLE, OP_CMPL, OP_CMPGE, OP_CMPG: begin
                if (d < 2) return FLT_UNDER;
                if ((op == OP_DIV || op == OP_MOD) && dstk[d-1] == 0) return FLT_DIVZ;
                dstk[d-2] = alu(op, dstk[d-2], dstk[d-1]);
                ddep = d - 1;
                ip = nxt;
            end
            OP_SWAP: begin
                if (d < 2) return FLT_UNDER;
                t = dstk[d-1];
                dstk[d-1] = dstk[d-2];
                dstk[d-2] = t;
                ip = nxt;
            end
            OP_DUP: begin
                if (d < 1) return FLT_UNDER;
                if (d >= DS_DEPTH) return FLT_OVER;
                dstk[d] = dstk[d-1];
                ddep = d + 1;
                ip = nxt;
            end
            OP_INSWAP: begin
                if (v >= d) return FLT_BADPOS;
                t = dstk[d-1];
                dstk[d-1] = dstk[d-1-p];
                dstk[d-1-p] = t;
                ip = nxt;
            end
            OP_INDUP: begin
                if (v >= d) return FLT_BADPOS;
                if (d >= DS_DEPTH) return FLT_OVER;
                dstk[d] = dstk[d-1-p];
                ddep = d + 1;
                ip = nxt;
            end
            OP_JMP: ip = v[ADDR_W-1:0];
            OP_JZ, OP_JLE, OP_JGE, OP_JL, OP_JG: begin
                if (d < 1) return FLT_UNDER;
                ddep = d - 1;
                ip = branch_taken(op, dstk[d-1]) ? v[ADDR_W-1:0] : nxt;
            end
            OP_CALL: begin
                if (rdep >= RS_DEPTH) return FLT_RSOVER;
                rstk[rdep] = ip;
                rdep++;
                ip = v[ADDR_W-1:0];
            end
            OP_RET: begin
                // Returning with nothing on the return stack stops cleanly.
                if (rdep == 0) begin
                    halted = 1'b1;
                end else begin
                    rdep--;
                    ip = rstk[rdep] + 1'b1;
                end
            end
            OP_SSP: begin
                if (d < 1) return FLT_UNDER;
                t = dstk[d-1];
                if (t > DS_DEPTH) return FLT_BADPOS;
                ddep = t;
                ip = nxt;
            end
            default: return FLT_BADOP;
        endcase
        return FLT_NONE;
    endfunction

    always @(posedge i_clk) begin
        t_status exp_s;
        t_status got;
        logic [FAULT_W-1:0] f;
        if (!i_rst_n) begin
            ddep = 0;
            rdep = 0;
            ip = '0;
            halted = 1'b0;
            status_q.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (i_pop && !i_empty) begin
                got = {i_next_address, i_top_value, i_depth, i_stopped, i_fault};
                if (status_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: status beat with nothing expected: %p", $time, got);
                end else begin
                    exp_s = status_q.pop_front();
                    o_checked++;
                    if (got !== exp_s) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: status mismatch, expected %p, got %p",
                                     $time, exp_s, got);
                    end
                end
            end
            if (i_push && !i_full) begin
                f = FLT_NONE;
                if (!halted) begin
                    f = run_instr(i_func, i_operand);
                    if (f != FLT_NONE) halted = 1'b1;
                end
                exp_s.next_address = ip;
                exp_s.top_value    = (ddep > 0) ? dstk[ddep-1] : '0;
                exp_s.depth        = ddep[DEPTH_W-1:0];
                exp_s.stopped      = halted;
                exp_s.fault        = f;
                status_q.push_back(exp_s);
            end
        end
        o_pending = status_q.size();
    end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the stack machine execute core
// Feeds instruction programs through the core and lets the checker compare
// every status beat. Only one halt can happen per run, so the program is kept
// fault free and ends with one randomly chosen stopping case.
// ----------------------------------------------------------------------------
module testbench;
    import smec_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_push;
    logic                o_full;
    logic [FUNC_W-1:0]   i_func;
    logic [DATA_W-1:0]   i_operand;
    logic                o_empty;
    logic                i_pop;
    logic [ADDR_W-1:0]   o_next_address;
    logic [DATA_W-1:0]   o_top_value;
    logic [DEPTH_W-1:0]  o_depth;
    logic                o_stopped;
    logic [FAULT_W-1:0]  o_fault;
    int                  fail_count;
    int                  pending;
    int                  checked;

    // Sender and receiver idling percentages for the current phase.
    int unsigned         send_idle_pct;
    int unsigned         pop_stall_pct;
    // Request for one long receiver hold-off; counted in the receiver process.
    bit                  hold_req;

    // Shadow stack depths, used to keep runs fault free up to the stopping case.
    int unsigned         sh_depth;
    int unsigned         sh_rdepth;
    int unsigned         sent;
    int unsigned         stop_case;

    stack_machine_execute_core u_dut (.*);

    smec_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_full         (o_full),
        .i_func         (i_func),
        .i_operand      (i_operand),
        .i_empty        (o_empty),
        .i_pop          (i_pop),
        .i_next_address (o_next_address),
        .i_top_value    (o_top_value),
        .i_depth        (o_depth),
        .i_stopped      (o_stopped),
        .i_fault        (o_fault),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The run must never hang, whatever the core does.
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: pops change on the falling edge. A long hold-off lets the
    // front end queue fill so that o_full has to push back on the sender.
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        i_pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop = 1'b0;
            end else begin
                i_pop = ($urandom_range(99) >= pop_stall_pct);
            end
        end
    end

    // Sends one instruction beat. Called just after a falling edge; returns
    // just after the falling edge that follows acceptance. Since o_full only
    // moves on a rising edge, its value at the falling edge decides the beat.
    task automatic send_instr(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] val);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_push    = 1'b1;
        i_func    = op;
        i_operand = val;
        do begin
            taken = !o_full;
            @(negedge i_clk);
        end while (!taken);
        i_push = 1'b0;
        sent++;
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return {$urandom, $urandom};
            3: return 64'(signed'($urandom_range(20)) - 10);
            default: return {{32{$urandom_range(1) == 1}}, $urandom};
        endcase
    endfunction

    // Emits one random but legal instruction, bending the opcode toward a push,
    // pop, call or return where the drawn one would fault at the current depths.
    task automatic random_instr();
        logic [FUNC_W-1:0] op;
        logic [DATA_W-1:0] w;
        int unsigned       new_depth;
        op = 5'($urandom_range(25));
        if (op == OP_HALT) op = OP_NOP;
        case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_CMPLE, OP_CMPL, OP_CMPGE, OP_CMPG, OP_SWAP:
                if (sh_depth < 2) op = OP_PUSH;
            OP_DIV, OP_MOD:
                if (sh_depth < 1) op = OP_PUSH;
                else if (sh_depth >= DS_DEPTH) op = OP_POP;
            OP_DUP, OP_INDUP, OP_SSP:
                if (sh_depth < 1) op = OP_PUSH;
                else if (sh_depth >= DS_DEPTH) op = OP_POP;
            OP_INSWAP, OP_POP, OP_JZ, OP_JLE, OP_JGE, OP_JL, OP_JG:
                if (sh_depth < 1) op = OP_PUSH;
            OP_CALL: if (sh_rdepth >= RS_DEPTH) op = OP_RET;
            OP_RET:  if (sh_rdepth == 0) op = OP_CALL;
            default: ;
        endcase
        if (op == OP_PUSH && sh_depth >= DS_DEPTH) op = OP_POP;
        case (op)
            OP_PUSH: begin
                send_instr(op, pick_word());
                sh_depth++;
            end
            OP_DIV, OP_MOD: begin
                // A nonzero divisor goes on first so that the step never faults.
                w = pick_word();
                if (w == 0) w = 64'd7;
                send_instr(OP_PUSH, w);
                send_instr(op, pick_word());
            end
            OP_SSP: begin
                // The new depth never rises above entries that hold data.
                new_depth = $urandom_range(sh_depth + 1);
                send_instr(OP_PUSH, 64'(new_depth));
                send_instr(op, pick_word());
                sh_depth = new_depth;
            end
            OP_INSWAP: send_instr(op, 64'($urandom_range(sh_depth - 1)));
            OP_INDUP: begin
                send_instr(op, 64'($urandom_range(sh_depth - 1)));
                sh_depth++;
            end
            OP_DUP: begin
                send_instr(op, pick_word());
                sh_depth++;
            end
            OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_CMPLE, OP_CMPL, OP_CMPGE, OP_CMPG,
            OP_JZ, OP_JLE, OP_JGE, OP_JL, OP_JG: begin
                send_instr(op, pick_word());
                sh_depth--;
            end
            OP_CALL: begin
                send_instr(op, pick_word());
                sh_rdepth++;
            end
            OP_RET: begin
                send_instr(op, pick_word());
                sh_rdepth--;
            end
            default: send_instr(op, pick_word());
        endcase
    endtask

    task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned count);
        send_idle_pct = idle;
        pop_stall_pct = stall;
        repeat (count) random_instr();
    endtask

    initial begin : stimulus
        int unsigned wait_cycles;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_func = OP_NOP;
        i_operand = '0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        sh_depth = 0;
        sh_rdepth = 0;
        sent = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: operand extremes, signed division and modulo, compares,
        // jumps both ways, call and return, indexed stack access and ssp.
        send_instr(OP_NOP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(OP_PUSH, 64'h8000_0000_0000_0000);
        send_instr(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(OP_DUP, '0);
        send_instr(OP_INDUP, 64'd2);
        send_instr(OP_DIV, '0);
        send_instr(OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_instr(OP_MOD, '0);
        send_instr(OP_INSWAP, 64'd2);
        send_instr(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_instr(OP_CMPLE, '0);
        send_instr(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_instr(OP_SWAP, '0);
        send_instr(OP_CMPG, '0);
        send_instr(OP_JZ, 64'h0000_0000_0001_0004);
        send_instr(OP_JMP, 64'h0000_0000_0000_FFFF);
        send_instr(OP_CALL, 64'h1234_5678_9ABC_FFFE);
        send_instr(OP_RET, '0);
        send_instr(OP_PUSH, 64'd1);
        send_instr(OP_SSP, '0);
        send_instr(OP_JGE, 64'h0000_0000_0000_00AA);
        send_instr(OP_PUSH, 64'd0);
        send_instr(OP_JLE, 64'h0000_0000_0000_0055);
        sh_depth = 0;
        sh_rdepth = 0;

        // Fill the data stack to its limit once, then drop it with ssp.
        while (sh_depth < DS_DEPTH) begin
            send_instr(OP_PUSH, pick_word());
            sh_depth++;
        end
        send_instr(OP_POP, '0);
        send_instr(OP_POP, '0);
        send_instr(OP_INDUP, 64'(DS_DEPTH - 3));
        sh_depth--;
        send_instr(OP_PUSH, 64'd3);
        send_instr(OP_SSP, '0);
        sh_depth = 3;

        run_phase(0, 0, 105);
        run_phase(75, 0, 105);
        run_phase(0, 75, 105);
        hold_req = 1'b1;
        run_phase(12, 12, 105);

        // Pick one way for the machine to stop, then a few ignored beats.
        send_idle_pct = 0;
        pop_stall_pct = 30;
        stop_case = $urandom_range(7);
        case (stop_case)
            0: send_instr(OP_HALT, pick_word());
            1: begin
                while (sh_rdepth > 0) begin
                    send_instr(OP_RET, '0);
                    sh_rdepth--;
                end
                send_instr(OP_RET, '0);
            end
            2: begin
                while (sh_depth > 0) begin
                    send_instr(OP_POP, '0);
                    sh_depth--;
                end
                send_instr(OP_ADD, '0);
            end
            3: begin
                while (sh_depth < DS_DEPTH) begin
                    send_instr(OP_PUSH, pick_word());
                    sh_depth++;
                end
                send_instr(OP_PUSH, pick_word());
            end
            4: begin
                if (sh_depth >= DS_DEPTH) send_instr(OP_POP, '0);
                send_instr(OP_PUSH, '0);
                send_instr(OP_MOD, '0);
            end
            5: send_instr(OP_INSWAP, 64'h8000_0000_0000_0000 | 64'($urandom_range(3)));
            6: begin
                while (sh_rdepth < RS_DEPTH) begin
                    send_instr(OP_CALL, pick_word());
                    sh_rdepth++;
                end
                send_instr(OP_CALL, pick_word());
            end
            default: send_instr(5'($urandom_range(31, 26)), pick_word());
        endcase
        repeat (6) send_instr(5'($urandom_range(31)), pick_word());

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(negedge i_clk);

        $display("Sent %0d instruction beats over four idling phases; %0d status beats checked.",
                 sent, checked);
        $display("Run ended with stopping case %0d; %0d beats still expected.",
                 stop_case, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
